// ===== src/undirected_edge_event_filter_unit_macros.svh =====
// assertion macros shared by the edge event filter checkers
`ifndef UNDIRECTED_EDGE_EVENT_FILTER_UNIT_MACROS_SVH
`define UNDIRECTED_EDGE_EVENT_FILTER_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define UEFU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("uefu: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define UEFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("uefu: next-cycle check failed");

`endif

// ===== src/uefu_pkg.sv =====
// types, constants and helper functions of the edge event filter
`default_nettype none

package uefu_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int VERTEX_BITS   = 20;

  localparam int VTX_W   = 20;
  localparam int TS_W    = 48;
  localparam int KEY_W   = 2 * VERTEX_BITS;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int IDXP_W  = IDX_W + 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int TDATA_W = ((2 * VTX_W + TS_W + 7) / 8) * 8;

  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TUSER_W = 3;

  // output tuser bit positions
  localparam int USR_EMIT = 0;
  localparam int USR_KIND = 1;
  localparam int USR_FULL = 2;

  localparam logic KIND_DEL = 1'b0;
  localparam logic KIND_INS = 1'b1;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0] idx_t;

  // used marks a slot that once held an edge, so a probe chain stops at a never-used slot
  typedef struct packed {
    logic used;
    logic valid;
    key_t key;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  typedef struct packed {
    logic done;
    logic found;
    logic free_ok;
    idx_t slot;
    idx_t free_slot;
  } probe_rsp_t;

  function automatic key_t make_key(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b);
    logic [VERTEX_BITS-1:0] va;
    logic [VERTEX_BITS-1:0] vb;
    va = VERTEX_BITS'(a);
    vb = VERTEX_BITS'(b);
    return {va, vb};
  endfunction

  // xor fold of the key onto the index, then one wrap into the table range
  function automatic idx_t hash_idx(input key_t k);
    logic [IDX_W-1:0]  h;
    logic [IDXP_W-1:0] hx;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ k[i];
    end
    hx = {1'b0, h};
    if (hx >= IDXP_W'(TABLE_ENTRIES)) begin
      hx = hx - IDXP_W'(TABLE_ENTRIES);
    end
    return hx[IDX_W-1:0];
  endfunction

  function automatic idx_t next_idx(input idx_t i);
    return (i == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : i + IDX_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== src/undirected_edge_event_filter_unit.sv =====
// top level of the undirected edge event filter: sequencer, edge table and result register
`default_nettype none

// Takes one directed edge insert or delete event at a time and returns one result that
// echoes it with an emit flag and a table-full flag. Active directed edges live in a
// hashed table in one ram, searched by a single probe unit that checks one slot per
// cycle along a linear probe chain; deleted slots stay on the chain as tombstones.
// An event runs a probe for the forward key, one for the reverse key, an update step
// and a result step that waits for the output register to be free. The next event is
// accepted when the result has been loaded. After reset a clearing pass writes every
// slot once before the first event is accepted.
module undirected_edge_event_filter_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // src_vertex, dst_vertex, timestamp
  input  wire logic [uefu_pkg::TDATA_W-1:0]       s_axis_tdata,
  // kind
  input  wire logic [uefu_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // src_out, dst_out, time_out
  output logic      [uefu_pkg::TDATA_W-1:0]       m_axis_tdata,
  // emit, kind_out, table_full
  output logic      [uefu_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

  import uefu_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FWD,
    S_BWD,
    S_UPD,
    S_OUT
  } seq_state_e;

  seq_state_e              state_q;
  idx_t                    clr_idx_q;
  logic [CNT_W-1:0]        count_q;
  logic                    start_q;
  logic [VTX_W-1:0]        src_q;
  logic [VTX_W-1:0]        dst_q;
  logic                    kind_q;
  logic [TS_W-1:0]         ts_q;
  logic                    fwd_found_q;
  idx_t                    fwd_slot_q;
  logic                    free_ok_q;
  idx_t                    free_slot_q;
  logic                    emit_q;
  logic                    full_q;
  logic                    m_valid_q;
  logic [TDATA_W-1:0]      m_data_q;
  logic [OUT_TUSER_W-1:0]  m_user_q;

  key_t       fwd_key;
  key_t       bwd_key;
  key_t       probe_key;
  logic       rd_en;
  idx_t       rd_addr;
  entry_t     rd_data;
  logic       we;
  idx_t       waddr;
  entry_t     wdata;
  probe_rsp_t rsp;
  logic       emit_d;
  logic       full_d;
  logic       count_inc;
  logic       count_dec;
  logic       out_free;

  assign fwd_key   = make_key(src_q, dst_q);
  assign bwd_key   = make_key(dst_q, src_q);
  assign probe_key = (state_q == S_BWD) ? bwd_key : fwd_key;
  assign out_free  = !m_valid_q || m_axis_tready;

  uefu_probe u_probe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .key_i     (probe_key),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .rsp_o     (rsp)
  );

  logic [ENT_W-1:0] rd_bits;

  uefu_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_bits)
  );

  assign rd_data = entry_t'(rd_bits);

  // table writes of the clearing pass, and the update decision acted on in the update cycle
  always_comb begin
    we        = 1'b0;
    waddr     = clr_idx_q;
    wdata     = '0;
    emit_d    = 1'b0;
    full_d    = 1'b0;
    count_inc = 1'b0;
    count_dec = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_UPD: begin
        if (kind_q == KIND_INS) begin
          if (!fwd_found_q) begin
            if (count_q == CNT_W'(TABLE_ENTRIES) || !free_ok_q) begin
              full_d = 1'b1;
            end else begin
              we        = 1'b1;
              waddr     = free_slot_q;
              wdata     = '{used: 1'b1, valid: 1'b1, key: fwd_key};
              count_inc = 1'b1;
              emit_d    = !rsp.found;
            end
          end
        end else begin
          if (fwd_found_q) begin
            we        = 1'b1;
            waddr     = fwd_slot_q;
            wdata     = '{used: 1'b1, valid: 1'b0, key: '0};
            count_dec = 1'b1;
            // a self loop finds the same slot in both directions
            emit_d    = !rsp.found || (rsp.slot == fwd_slot_q);
          end
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_idx_q <= '0;
      count_q   <= '0;
      start_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      // probe starts after an input transfer and again after the forward probe
      start_q <= ((state_q == S_IDLE) && s_axis_tvalid) || ((state_q == S_FWD) && rsp.done);
      if ((state_q == S_OUT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_idx_q <= next_idx(clr_idx_q);
          if (clr_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            src_q   <= s_axis_tdata[VTX_W-1:0];
            dst_q   <= s_axis_tdata[2*VTX_W-1:VTX_W];
            ts_q    <= s_axis_tdata[2*VTX_W+TS_W-1:2*VTX_W];
            kind_q  <= s_axis_tuser[0];
            state_q <= S_FWD;
          end
        end
        S_FWD: begin
          if (rsp.done) begin
            fwd_found_q <= rsp.found;
            fwd_slot_q  <= rsp.slot;
            free_ok_q   <= rsp.free_ok;
            free_slot_q <= rsp.free_slot;
            state_q     <= S_BWD;
          end
        end
        S_BWD: begin
          if (rsp.done) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          emit_q <= emit_d;
          full_q <= full_d;
          if (count_inc) begin
            count_q <= count_q + CNT_W'(1);
          end else if (count_dec) begin
            count_q <= count_q - CNT_W'(1);
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_data_q                 <= TDATA_W'({ts_q, dst_q, src_q});
            m_user_q[USR_EMIT]       <= emit_q;
            m_user_q[USR_KIND]       <= kind_q;
            m_user_q[USR_FULL]       <= full_q;
            state_q                  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

// ===== src/uefu_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module uefu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/uefu_probe.sv =====
// linear probe unit: walks the hash chain of one key, one slot per cycle
`default_nettype none

module uefu_probe (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire uefu_pkg::key_t      key_i,
  output logic                     rd_en_o,
  output uefu_pkg::idx_t           rd_addr_o,
  input  wire uefu_pkg::entry_t    rd_data_i,
  output uefu_pkg::probe_rsp_t     rsp_o
);

  import uefu_pkg::*;

  typedef enum logic {
    P_IDLE,
    P_SCAN
  } probe_state_e;

  probe_state_e state_q;
  idx_t         addr_q;
  idx_t         cnt_q;
  idx_t         slot_q;
  idx_t         free_slot_q;
  logic         free_ok_q;
  logic         found_q;
  logic         done_q;

  logic hit;
  logic stop;
  idx_t start_addr;

  assign start_addr = hash_idx(key_i);
  assign hit        = rd_data_i.valid && (rd_data_i.key == key_i);
  // a never-used slot ends the chain, and so does a full lap of the table
  assign stop       = !rd_data_i.used || (cnt_q == IDX_W'(TABLE_ENTRIES - 1));

  always_comb begin
    rd_en_o   = 1'b0;
    rd_addr_o = addr_q;
    unique case (state_q)
      P_IDLE: begin
        rd_en_o   = start_i;
        rd_addr_o = start_addr;
      end
      P_SCAN: begin
        rd_en_o   = !hit && !stop;
        rd_addr_o = next_idx(addr_q);
      end
      default: begin
        rd_en_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= P_IDLE;
      done_q    <= 1'b0;
      found_q   <= 1'b0;
      free_ok_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      unique case (state_q)
        P_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            addr_q    <= start_addr;
            cnt_q     <= '0;
            free_ok_q <= 1'b0;
            found_q   <= 1'b0;
            state_q   <= P_SCAN;
          end
        end
        P_SCAN: begin
          // first free slot on the chain is where an insertion lands
          if (!rd_data_i.valid && !free_ok_q) begin
            free_ok_q   <= 1'b1;
            free_slot_q <= addr_q;
          end
          if (hit) begin
            found_q <= 1'b1;
            slot_q  <= addr_q;
            done_q  <= 1'b1;
            state_q <= P_IDLE;
          end else if (stop) begin
            found_q <= 1'b0;
            done_q  <= 1'b1;
            state_q <= P_IDLE;
          end else begin
            addr_q <= next_idx(addr_q);
            cnt_q  <= cnt_q + IDX_W'(1);
          end
        end
        default: begin
          state_q <= P_IDLE;
        end
      endcase
    end
  end

  assign rsp_o = '{done:      done_q,
                   found:     found_q,
                   free_ok:   free_ok_q,
                   slot:      slot_q,
                   free_slot: free_slot_q};

endmodule

`default_nettype wire

// ===== src/uefu_checker.sv =====
// port-level checks of the edge event filter, bound to the top level
`default_nettype none

`include "undirected_edge_event_filter_unit_macros.svh"

module uefu_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               s_axis_tvalid,
  input wire logic                               s_axis_tready,
  input wire logic [uefu_pkg::TDATA_W-1:0]       s_axis_tdata,
  input wire logic [uefu_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [uefu_pkg::TDATA_W-1:0]       m_axis_tdata,
  input wire logic [uefu_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

  import uefu_pkg::*;

  // one event in flight: an accepted transfer closes the input in the cycle after it
  `UEFU_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a dropped insertion is never passed on
  `UEFU_ASSERT_NOW(a_full_no_emit, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[USR_FULL], !m_axis_tuser[USR_EMIT])

  // only insertions can see a full table
  `UEFU_ASSERT_NOW(a_del_not_full, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser[USR_KIND] == KIND_DEL), !m_axis_tuser[USR_FULL])

  `UEFU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  logic unused_in;
  assign unused_in = ^{s_axis_tdata, s_axis_tuser};

endmodule

bind undirected_edge_event_filter_unit uefu_checker u_checker (.*);

`default_nettype wire

// ===== dv/undirected_edge_event_filter_unit_test.sv =====
// self-checking testbench of the undirected edge event filter
`default_nettype none

module undirected_edge_event_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import uefu_pkg::*;

  localparam int IDLE_PCT      = 22;
  localparam int POOL_SIZE     = 12;
  localparam int RANDOM_EVENTS = 350;
  localparam int BURST_EVENTS  = 120;
  // the two probe chains of an event can each cover the whole table
  localparam int SETTLE_CYCLES = 2 * TABLE_ENTRIES + 16;
  localparam int QUIET_LIMIT   = 16 * TABLE_ENTRIES;
  localparam int MAX_REPORTS   = 40;

  typedef logic [VTX_W-1:0] vertex_t;
  typedef logic [TS_W-1:0]  stamp_t;
  typedef bit [KEY_W-1:0]   edge_key_t;

  typedef struct packed {
    logic    emit;
    vertex_t src;
    vertex_t dst;
    logic    kind;
    stamp_t  stamp;
    logic    full;
  } filter_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic [IN_TUSER_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  // directed edges currently held by the block, and how many
  bit active_edges[edge_key_t];
  int unsigned live_edges;
  filter_result_t expected_results[$];
  vertex_t vertex_pool[POOL_SIZE];
  bit no_idle;
  int error_count;
  int quiet_cycles;

  undirected_edge_event_filter_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic edge_key_t edge_code(input vertex_t a, input vertex_t b);
    return {a[VERTEX_BITS-1:0], b[VERTEX_BITS-1:0]};
  endfunction

  // applies one event to the edge set and returns the result it must produce
  function automatic filter_result_t filter_edge_event(input vertex_t src, input vertex_t dst,
                                                       input logic kind, input stamp_t stamp);
    filter_result_t r;
    edge_key_t fwd;
    edge_key_t bwd;
    bit fwd_hit;
    bit bwd_hit;
    fwd = edge_code(src, dst);
    bwd = edge_code(dst, src);
    fwd_hit = active_edges.exists(fwd);
    bwd_hit = active_edges.exists(bwd);
    r = '{emit: 1'b0, src: src, dst: dst, kind: kind, stamp: stamp, full: 1'b0};
    if (kind == KIND_INS) begin
      if (!fwd_hit) begin
        if (live_edges == TABLE_ENTRIES) begin
          r.full = 1'b1;
        end else begin
          active_edges[fwd] = 1'b1;
          live_edges++;
          r.emit = !bwd_hit;
        end
      end
    end else if (fwd_hit) begin
      active_edges.delete(fwd);
      live_edges--;
      // a self loop is its own reverse, so it is gone now too
      r.emit = !bwd_hit || (fwd == bwd);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want,
                             input vertex_t src, input vertex_t dst);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got %0h want %0h (edge %0h -> %0h)",
                                name, got, want, src, dst));
    end
  endtask

  task automatic send_event(input vertex_t src, input vertex_t dst, input logic kind,
                            input stamp_t stamp);
    filter_result_t want;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'({stamp, dst, src});
    s_axis_tuser  <= IN_TUSER_W'(kind);
    do @(posedge clk_i); while (!s_axis_tready);
    want = filter_edge_event(src, dst, kind, stamp);
    expected_results.insert(expected_results.size(), want);
  endtask

  // sender holds off until every outstanding result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic stamp_t random_stamp();
    return TS_W'({$urandom, $urandom});
  endfunction

  task automatic test_edge_pairs();
    vertex_t a;
    vertex_t b;
    a = VTX_W'($urandom);
    b = a ^ VTX_W'(1 + $urandom_range(1000));
    send_event(a, b, KIND_INS, random_stamp());  // new undirected edge
    send_event(a, b, KIND_INS, random_stamp());  // repeated insertion
    send_event(b, a, KIND_INS, random_stamp());  // reverse already active
    send_event(a, b, KIND_DEL, random_stamp());  // reverse still active
    send_event(a, b, KIND_DEL, random_stamp());  // already gone
    send_event(b, a, KIND_DEL, random_stamp());  // last direction leaves
    send_event(b, b ^ 20'h5a5a5, KIND_DEL, random_stamp());  // never inserted
    send_event(b, a, KIND_INS, random_stamp());
    send_event(b, a, KIND_DEL, random_stamp());
    wait_drained();
  endtask

  task automatic test_self_loops_and_extremes();
    vertex_t s;
    s = VTX_W'($urandom);
    send_event(s, s, KIND_INS, random_stamp());
    send_event(s, s, KIND_INS, random_stamp());
    send_event(s, s, KIND_DEL, random_stamp());
    send_event('0, '1, KIND_INS, '0);
    send_event('1, '0, KIND_INS, '1);
    send_event('0, '0, KIND_INS, '1);
    send_event('1, '1, KIND_INS, '0);
    send_event('1, '0, KIND_DEL, '1);
    send_event('0, '1, KIND_DEL, '0);
    send_event('0, '0, KIND_DEL, '0);
    send_event('1, '1, KIND_DEL, '1);
    wait_drained();
  endtask

  // mostly insert/delete traffic over a small vertex set, with some wide noise
  task automatic send_random_event();
    vertex_t a;
    vertex_t b;
    logic k;
    if ($urandom_range(99) < 8) begin
      a = VTX_W'($urandom);
      b = VTX_W'($urandom);
      k = $urandom_range(1) ? KIND_INS : KIND_DEL;
    end else begin
      a = vertex_pool[$urandom_range(POOL_SIZE - 1)];
      b = ($urandom_range(9) == 0) ? a : vertex_pool[$urandom_range(POOL_SIZE - 1)];
      k = ($urandom_range(99) < 55) ? KIND_INS : KIND_DEL;
    end
    send_event(a, b, k, random_stamp());
  endtask

  task automatic test_random_events();
    vertex_pool[0] = '0;
    vertex_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      vertex_pool[i] = VTX_W'($urandom);
    end
    repeat (RANDOM_EVENTS) send_random_event();
    wait_drained();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (BURST_EVENTS) send_random_event();
    wait_drained();
    no_idle = 1'b0;
  endtask

  task automatic test_table_full();
    vertex_t a;
    vertex_t b;
    a = '0;
    b = '0;
    while (live_edges < TABLE_ENTRIES) begin
      a = VTX_W'($urandom);
      b = VTX_W'($urandom);
      if (!active_edges.exists(edge_code(a, b))) begin
        send_event(a, b, KIND_INS, random_stamp());
      end
    end
    send_event(b, a, KIND_INS, random_stamp());  // dropped although reverse is active
    send_event(a ^ 20'h00f0f, b, KIND_INS, random_stamp());
    send_event(a, b, KIND_INS, random_stamp());  // present, so not flagged
    send_event(a ^ 20'h00f0f, b, KIND_DEL, random_stamp());
    send_event(a, b, KIND_DEL, random_stamp());
    send_event(b, a, KIND_INS, random_stamp());  // one slot was freed
    send_event(b, b, KIND_INS, random_stamp());
    send_event(b, a, KIND_DEL, random_stamp());
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && (no_idle || $urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    filter_result_t got;
    filter_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.src   = m_axis_tdata[VTX_W-1:0];
      got.dst   = m_axis_tdata[2*VTX_W-1:VTX_W];
      got.stamp = m_axis_tdata[2*VTX_W+TS_W-1:2*VTX_W];
      got.emit  = m_axis_tuser[USR_EMIT];
      got.kind  = m_axis_tuser[USR_KIND];
      got.full  = m_axis_tuser[USR_FULL];
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result for edge %0h -> %0h with no event pending",
                                  got.src, got.dst));
      end else begin
        want = expected_results.pop_front();
        check_field("emit", 64'(got.emit), 64'(want.emit), want.src, want.dst);
        check_field("src_out", 64'(got.src), 64'(want.src), want.src, want.dst);
        check_field("dst_out", 64'(got.dst), 64'(want.dst), want.src, want.dst);
        check_field("kind_out", 64'(got.kind), 64'(want.kind), want.src, want.dst);
        check_field("time_out", 64'(got.stamp), 64'(want.stamp), want.src, want.dst);
        check_field("table_full", 64'(got.full), 64'(want.full), want.src, want.dst);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    no_idle       = 1'b0;
    live_edges    = 0;
    error_count   = 0;
    quiet_cycles  = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_edge_pairs();
    test_self_loops_and_extremes();
    test_random_events();
    test_back_to_back();
    test_table_full();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/uefu_pkg.sv
src/uefu_ram.sv
src/uefu_probe.sv
src/undirected_edge_event_filter_unit.sv
src/uefu_checker.sv
dv/undirected_edge_event_filter_unit_test.sv
